// ----- sv/rmth_pkg.sv -----
// rmth_pkg: types, sizes and helpers for the running median block
// no dependencies

package rmth_pkg;

  localparam int unsigned HALF_DEPTH = 512;
  localparam int unsigned AW = $clog2(HALF_DEPTH);
  localparam int unsigned SW = AW + 1;
  localparam int unsigned CW = AW + 2;
  localparam logic [CW-1:0] FULL_COUNT = CW'(2 * HALF_DEPTH);

  typedef struct packed {
    logic signed [31:0] sample;
    logic               restart;
  } rmth_in_t;

  typedef struct packed {
    logic signed [31:0] median;
    logic [10:0]        stored_count;
    logic               rejected;
  } rmth_out_t;

  typedef enum logic {
    HEAP_LO,
    HEAP_UP
  } heap_sel_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_POP_LAST,
    S_POP_RD,
    S_POP_CMP,
    S_PUSH,
    S_PUSH_CMP,
    S_FIN
  } rmth_state_e;

  // true when a belongs above b in the selected heap
  function automatic logic ranks_above(logic signed [31:0] a, logic signed [31:0] b,
                                       heap_sel_e sel);
    logic r;
    r = (sel == HEAP_LO) ? (a > b) : (a < b);
    return r;
  endfunction

endpackage

// ----- sv/rmth_ram.sv -----
// rmth_ram: one write port, two registered read ports
// no dependencies

module rmth_ram #(
  parameter int unsigned DEPTH = 512,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr0_i,
  input  logic [$clog2(DEPTH)-1:0] raddr1_i,
  output logic [WIDTH-1:0]         rdata0_o,
  output logic [WIDTH-1:0]         rdata1_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata0_o <= mem[raddr0_i];
    rdata1_o <= mem[raddr1_i];
  end

endmodule

// ----- sv/running_median_two_heaps.sv -----
// running_median_two_heaps: top level, heap sequencer over two heap memories
// depends on rmth_pkg and rmth_ram
//
// Each item passes S_IDLE, S_DECIDE and S_FIN; a push climbs one heap level
// per S_PUSH/S_PUSH_CMP pass (read parent, compare and write), and a pop reads
// the last element in S_POP_LAST, then sinks one level per S_POP_RD/S_POP_CMP
// pass (read both children, compare and write). The heap tops are also held
// in registers, so each decision needs no memory read. One item is worked on
// at a time; the result sits in an output register while the next is taken.

module running_median_two_heaps
  import rmth_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  rmth_in_t  in_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output rmth_out_t out_o
);

  rmth_state_e state_q, state_d;
  logic [SW-1:0] size_q [2];
  logic [SW-1:0] size_d [2];
  heap_sel_e sel_q, sel_d, src_q, src_d;
  logic [AW-1:0] idx_q, idx_d;
  logic signed [31:0] pv_q, pv_d, samp_q, samp_d, last_q, last_d;
  logic pend_q, pend_d, rej_q, rej_d;
  logic signed [31:0] top_q [2];
  logic out_valid_q, out_valid_d;
  rmth_out_t out_q, out_d;

  logic we;
  logic [AW-1:0] waddr, ra0, ra1;
  logic signed [31:0] wdata;
  logic [31:0] rd_lo0, rd_lo1, rd_up0, rd_up1;
  logic signed [31:0] rd0, rd1, bd;
  logic [AW:0] c_ext;
  logic [AW-1:0] best;
  logic [CW-1:0] total;
  logic signed [32:0] sum;
  logic signed [32:0] half;

  rmth_ram #(.DEPTH(HALF_DEPTH), .WIDTH(32)) u_lo (
    .clk_i, .we_i(we && sel_q == HEAP_LO), .waddr_i(waddr), .wdata_i(wdata),
    .raddr0_i(ra0), .raddr1_i(ra1), .rdata0_o(rd_lo0), .rdata1_o(rd_lo1)
  );

  rmth_ram #(.DEPTH(HALF_DEPTH), .WIDTH(32)) u_up (
    .clk_i, .we_i(we && sel_q == HEAP_UP), .waddr_i(waddr), .wdata_i(wdata),
    .raddr0_i(ra0), .raddr1_i(ra1), .rdata0_o(rd_up0), .rdata1_o(rd_up1)
  );

  assign rd0 = (sel_q == HEAP_LO) ? rd_lo0 : rd_up0;
  assign rd1 = (sel_q == HEAP_LO) ? rd_lo1 : rd_up1;
  assign c_ext = {idx_q, 1'b1};
  assign total = CW'(size_q[0]) + CW'(size_q[1]);
  assign sum = 33'(top_q[0]) + 33'(top_q[1]);
  assign half = (sum + 33'(sum[32] & sum[0])) >>> 1;

  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o = out_q;

  always_comb begin
    state_d = state_q;
    size_d = size_q;
    sel_d = sel_q;
    src_d = src_q;
    idx_d = idx_q;
    pv_d = pv_q;
    samp_d = samp_q;
    last_d = last_q;
    pend_d = pend_q;
    rej_d = rej_q;
    out_valid_d = out_valid_q;
    out_d = out_q;
    we = 1'b0;
    waddr = idx_q;
    wdata = pv_q;
    ra0 = '0;
    ra1 = '0;
    best = c_ext[AW-1:0];
    bd = rd0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          samp_d = in_i.sample;
          if (in_i.restart) begin
            size_d[0] = '0;
            size_d[1] = '0;
          end
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        rej_d = 1'b0;
        pend_d = 1'b0;
        pv_d = samp_q;
        if (total >= FULL_COUNT) begin
          rej_d = 1'b1;
          state_d = S_FIN;
        end else if (size_q[0] == '0) begin
          sel_d = HEAP_LO;
          idx_d = size_q[0][AW-1:0];
          size_d[0] = size_q[0] + 1'b1;
          state_d = S_PUSH;
        end else if (size_q[0] == size_q[1]) begin
          sel_d = (samp_q < top_q[0]) ? HEAP_LO : HEAP_UP;
          idx_d = size_q[sel_d][AW-1:0];
          size_d[sel_d] = size_q[sel_d] + 1'b1;
          state_d = S_PUSH;
        end else if ((size_q[0] < size_q[1] && samp_q <= top_q[1]) ||
                     (size_q[0] > size_q[1] && samp_q >= top_q[0])) begin
          sel_d = (size_q[0] < size_q[1]) ? HEAP_LO : HEAP_UP;
          idx_d = size_q[sel_d][AW-1:0];
          size_d[sel_d] = size_q[sel_d] + 1'b1;
          state_d = S_PUSH;
        end else begin
          // move the top of the larger heap across, then push the sample into the larger heap
          src_d = (size_q[0] < size_q[1]) ? HEAP_UP : HEAP_LO;
          sel_d = src_d;
          pend_d = 1'b1;
          pv_d = top_q[src_d];
          size_d[src_d] = size_q[src_d] - 1'b1;
          ra0 = size_d[src_d][AW-1:0];
          idx_d = '0;
          if (size_d[src_d] == '0) begin
            sel_d = heap_sel_e'(~src_d);
            idx_d = size_q[sel_d][AW-1:0];
            size_d[sel_d] = size_q[sel_d] + 1'b1;
            state_d = S_PUSH;
          end else begin
            state_d = S_POP_LAST;
          end
        end
      end
      S_POP_LAST: begin
        last_d = rd0;
        state_d = S_POP_RD;
      end
      S_POP_RD: begin
        if (c_ext >= size_q[sel_q]) begin
          we = 1'b1;
          wdata = last_q;
          sel_d = heap_sel_e'(~sel_q);
          idx_d = size_q[sel_d][AW-1:0];
          size_d[sel_d] = size_q[sel_d] + 1'b1;
          state_d = S_PUSH;
        end else begin
          ra0 = c_ext[AW-1:0];
          ra1 = c_ext[AW-1:0] + 1'b1;
          state_d = S_POP_CMP;
        end
      end
      S_POP_CMP: begin
        if (c_ext < size_q[sel_q] - 1'b1 && ranks_above(rd1, rd0, sel_q)) begin
          best = c_ext[AW-1:0] + 1'b1;
          bd = rd1;
        end
        we = 1'b1;
        if (ranks_above(bd, last_q, sel_q)) begin
          wdata = bd;
          idx_d = best;
          state_d = S_POP_RD;
        end else begin
          wdata = last_q;
          sel_d = heap_sel_e'(~sel_q);
          idx_d = size_q[sel_d][AW-1:0];
          size_d[sel_d] = size_q[sel_d] + 1'b1;
          state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        if (idx_q == '0) begin
          we = 1'b1;
          if (pend_q) begin
            pend_d = 1'b0;
            sel_d = src_q;
            pv_d = samp_q;
            idx_d = size_q[src_q][AW-1:0];
            size_d[src_q] = size_q[src_q] + 1'b1;
          end else begin
            state_d = S_FIN;
          end
        end else begin
          ra0 = (idx_q - 1'b1) >> 1;
          state_d = S_PUSH_CMP;
        end
      end
      S_PUSH_CMP: begin
        we = 1'b1;
        if (ranks_above(pv_q, rd0, sel_q)) begin
          wdata = rd0;
          idx_d = (idx_q - 1'b1) >> 1;
          state_d = S_PUSH;
        end else if (pend_q) begin
          pend_d = 1'b0;
          sel_d = src_q;
          pv_d = samp_q;
          idx_d = size_q[src_q][AW-1:0];
          size_d[src_q] = size_q[src_q] + 1'b1;
          state_d = S_PUSH;
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d.rejected = rej_q;
          out_d.stored_count = 11'(total);
          if (total == '0) begin
            out_d.median = '0;
          end else if (size_q[0] == size_q[1]) begin
            out_d.median = half[31:0];
          end else if (size_q[0] < size_q[1]) begin
            out_d.median = top_q[1];
          end else begin
            out_d.median = top_q[0];
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      size_q[0] <= '0;
      size_q[1] <= '0;
      out_valid_q <= 1'b0;
      pend_q <= 1'b0;
    end else begin
      state_q <= state_d;
      size_q <= size_d;
      out_valid_q <= out_valid_d;
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sel_q <= sel_d;
    src_q <= src_d;
    idx_q <= idx_d;
    pv_q <= pv_d;
    samp_q <= samp_d;
    last_q <= last_d;
    rej_q <= rej_d;
    out_q <= out_d;
    if (we && waddr == '0) begin
      top_q[sel_q] <= wdata;
    end
  end

endmodule

// ----- sv/rmth_checker.sv -----
// rmth_checker: port-level checks for running_median_two_heaps, with bind
// depends on rmth_pkg

module rmth_checker
  import rmth_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input rmth_in_t  in_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input rmth_out_t out_o
);

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_i))
    else $error("item changed while waiting");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o))
    else $error("result changed while stalled");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 12'(out_o.stored_count) <= 12'(FULL_COUNT))
    else $error("count above capacity");

  a_reject_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.rejected |-> 12'(out_o.stored_count) == 12'(FULL_COUNT))
    else $error("reject without full store");

  a_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_o.stored_count != '0)
    else $error("empty set after an item");

endmodule

bind running_median_two_heaps rmth_checker u_rmth_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
  .in_i(in_i), .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_o(out_o)
);
